// File: rtl/stx_etx_escape_deframer_assert.svh
// Assertion macros used by the deframer RTL.
// They assume the enclosing module has clk and an active-low rst_n.
`ifndef STX_ETX_ESCAPE_DEFRAMER_ASSERT_SVH
`define STX_ETX_ESCAPE_DEFRAMER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define STXD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define STXD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/stxd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stxd_pkg
// Types and codes shared by the start/end/escape byte deframer.
// ----------------------------------------------------------------------------
package stxd_pkg;

  // Framing mode of the receiver.
  typedef enum logic [1:0] {
    MODE_HUNT   = 2'd0,
    MODE_EXPECT = 2'd1,
    MODE_ASM    = 2'd2
  } mode_t;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_END  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  // Error codes reported with an error result.
  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_GARBAGE   = 3'd1,
    ERR_BADESC    = 3'd2,
    ERR_BARESTART = 3'd3,
    ERR_OVERFLOW  = 3'd4
  } err_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_START  = 2'd0,
    CFG_END    = 2'd1,
    CFG_ESCAPE = 2'd2,
    CFG_MAXLEN = 2'd3
  } cfg_idx_t;

  // Reset values of the configuration registers.
  localparam logic [7:0]  START_RST  = 8'd2;
  localparam logic [7:0]  END_RST    = 8'd3;
  localparam logic [7:0]  ESCAPE_RST = 8'd27;
  localparam logic [15:0] MAXLEN_RST = 16'd4096;

  typedef struct packed {
    logic [7:0]  start_byte;
    logic [7:0]  end_byte;
    logic [7:0]  escape_byte;
    logic [15:0] max_length;
  } cfg_t;

  typedef struct packed {
    mode_t       mode;
    logic        esc_pend;
    logic [7:0]  prev_byte;
    logic [15:0] length;
  } state_t;

  // One result item.
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload;
    logic [15:0] count;
    err_t        err;
  } item_t;

endpackage

// File: rtl/stxd_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stxd_step
// Per-byte framing decision: next state and the optional result item.
// ----------------------------------------------------------------------------
module stxd_step (
  input  stxd_pkg::cfg_t   cfg,
  input  stxd_pkg::state_t state,
  input  logic [7:0]       rx_byte,
  output stxd_pkg::state_t state_nxt,
  output logic             res_valid,
  output stxd_pkg::item_t  res_item
);

  logic        is_start;
  logic        is_end;
  logic        is_esc;
  logic        naked_start;
  logic [16:0] len_inc;
  logic        overflow;

  // Byte classification against the configured framing bytes.
  assign is_start    = (rx_byte == cfg.start_byte);
  assign is_end      = (rx_byte == cfg.end_byte);
  assign is_esc      = (rx_byte == cfg.escape_byte);
  assign naked_start = is_start && (state.prev_byte != cfg.escape_byte);
  assign len_inc     = {1'b0, state.length} + 17'd1;
  assign overflow    = (len_inc > {1'b0, cfg.max_length});

  always_comb begin
    state_nxt           = state;
    state_nxt.prev_byte = rx_byte;
    res_valid           = 1'b0;
    res_item.kind       = stxd_pkg::KIND_DATA;
    res_item.payload    = 8'd0;
    res_item.count      = 16'd0;
    res_item.err        = stxd_pkg::ERR_NONE;

    case (state.mode)
      stxd_pkg::MODE_EXPECT: begin
        if (naked_start) begin
          state_nxt.mode     = stxd_pkg::MODE_ASM;
          state_nxt.esc_pend = 1'b0;
          state_nxt.length   = 16'd0;
        end else begin
          state_nxt.mode     = stxd_pkg::MODE_HUNT;
          state_nxt.esc_pend = 1'b0;
          res_valid          = 1'b1;
          res_item.kind      = stxd_pkg::KIND_ERR;
          res_item.err       = stxd_pkg::ERR_GARBAGE;
        end
      end
      stxd_pkg::MODE_ASM: begin
        // Payload path is shared by escaped and plain bytes.
        if ((state.esc_pend && (is_start || is_end || is_esc)) ||
            (!state.esc_pend && !is_end && !is_esc && !is_start)) begin
          state_nxt.esc_pend = 1'b0;
          res_valid          = 1'b1;
          if (overflow) begin
            state_nxt.mode   = stxd_pkg::MODE_HUNT;
            state_nxt.length = 16'd0;
            res_item.kind    = stxd_pkg::KIND_ERR;
            res_item.err     = stxd_pkg::ERR_OVERFLOW;
          end else begin
            state_nxt.length = len_inc[15:0];
            res_item.payload = rx_byte;
            res_item.count   = len_inc[15:0];
          end
        end else if (state.esc_pend) begin
          // Only a framing byte may follow an escape.
          state_nxt.mode     = stxd_pkg::MODE_HUNT;
          state_nxt.esc_pend = 1'b0;
          res_valid          = 1'b1;
          res_item.kind      = stxd_pkg::KIND_ERR;
          res_item.err       = stxd_pkg::ERR_BADESC;
        end else if (is_end) begin
          state_nxt.mode     = stxd_pkg::MODE_EXPECT;
          state_nxt.esc_pend = 1'b0;
          res_valid          = 1'b1;
          res_item.kind      = stxd_pkg::KIND_END;
          res_item.count     = state.length;
        end else if (is_esc) begin
          state_nxt.esc_pend = 1'b1;
        end else begin
          // A start byte inside a frame.
          state_nxt.mode     = stxd_pkg::MODE_HUNT;
          state_nxt.esc_pend = 1'b0;
          res_valid          = 1'b1;
          res_item.kind      = stxd_pkg::KIND_ERR;
          res_item.err       = stxd_pkg::ERR_BARESTART;
        end
      end
      default: begin
        // Hunting; the unused mode code behaves the same way.
        state_nxt.esc_pend = 1'b0;
        if (naked_start) begin
          state_nxt.mode   = stxd_pkg::MODE_ASM;
          state_nxt.length = 16'd0;
        end else begin
          state_nxt.mode   = stxd_pkg::MODE_HUNT;
        end
      end
    endcase
  end

endmodule

// File: rtl/stx_etx_escape_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stx_etx_escape_deframer
// Start/end/escape byte deframer with running payload length and errors.
// ----------------------------------------------------------------------------
// One received byte is taken per transfer and decided in the same cycle; its
// result, if any, is registered in the first free output entry. It sustains
// one byte per clock while in_tready is high. A two-entry output buffer
// (result register plus skid register) decouples the sides, so in_tready drops
// only when both entries hold results the sink has not taken. Configuration
// writes take effect on the next byte; write them while no byte is in flight.
module stx_etx_escape_deframer (
  input  logic        clk,
  input  logic        rst_n,
  // Input byte stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] payload_byte, [23:8] byte_count,
                                  // [26:24] error_code, [31:27] zero
  output logic [1:0]  out_tuser,  // [1:0] kind
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

`include "stx_etx_escape_deframer_assert.svh"

  stxd_pkg::cfg_t   cfg_r;
  stxd_pkg::state_t state_r;
  stxd_pkg::state_t state_nxt;
  logic             res_valid;
  stxd_pkg::item_t  res_item;
  logic             in_accept;

  logic             out_valid_r;
  logic             out_valid_nxt;
  stxd_pkg::item_t  out_item_r;
  stxd_pkg::item_t  out_item_nxt;
  logic             skid_valid_r;
  logic             skid_valid_nxt;
  stxd_pkg::item_t  skid_item_r;
  stxd_pkg::item_t  skid_item_nxt;

  assign in_tready = !skid_valid_r;
  assign in_accept = in_tvalid && in_tready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte  <= stxd_pkg::START_RST;
      cfg_r.end_byte    <= stxd_pkg::END_RST;
      cfg_r.escape_byte <= stxd_pkg::ESCAPE_RST;
      cfg_r.max_length  <= stxd_pkg::MAXLEN_RST;
    end else if (cfg_we) begin
      case (stxd_pkg::cfg_idx_t'(cfg_index))
        stxd_pkg::CFG_START:  cfg_r.start_byte  <= cfg_wdata[7:0];
        stxd_pkg::CFG_END:    cfg_r.end_byte    <= cfg_wdata[7:0];
        stxd_pkg::CFG_ESCAPE: cfg_r.escape_byte <= cfg_wdata[7:0];
        stxd_pkg::CFG_MAXLEN: cfg_r.max_length  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Per-byte decision logic.
  stxd_step u_step (
    .cfg       (cfg_r),
    .state     (state_r),
    .rx_byte   (in_tdata),
    .state_nxt (state_nxt),
    .res_valid (res_valid),
    .res_item  (res_item)
  );

  // Framing state advances on every accepted byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mode      <= stxd_pkg::MODE_HUNT;
      state_r.esc_pend  <= 1'b0;
      state_r.prev_byte <= 8'd0;
      state_r.length    <= 16'd0;
    end else if (in_accept) begin
      state_r <= state_nxt;
    end
  end

  // Output buffer: drain first, then place a new result in the first free entry.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_item_nxt   = out_item_r;
    skid_valid_nxt = skid_valid_r;
    skid_item_nxt  = skid_item_r;
    if (out_valid_r && out_tready) begin
      if (skid_valid_r) begin
        out_item_nxt   = skid_item_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt  = 1'b0;
      end
    end
    if (in_accept && res_valid) begin
      if (!out_valid_nxt) begin
        out_valid_nxt  = 1'b1;
        out_item_nxt   = res_item;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_item_nxt  = res_item;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r  <= out_item_nxt;
    skid_item_r <= skid_item_nxt;
  end

  // Result port.
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_item_r.kind;
  assign out_tdata  = {5'd0, out_item_r.err, out_item_r.count, out_item_r.payload};

  // Checks.
  `STXD_ASSERT_NOW(a_skid_behind_out, skid_valid_r, out_valid_r,
    "skid entry holds a result while the output register is empty")
  `STXD_ASSERT_NOW(a_esc_only_asm, state_r.esc_pend, state_r.mode == stxd_pkg::MODE_ASM,
    "escape pending outside of frame assembly")
  `STXD_ASSERT_NOW(a_err_fields, out_valid_r && out_item_r.kind == stxd_pkg::KIND_ERR,
    out_item_r.err != stxd_pkg::ERR_NONE && out_item_r.count == 16'd0,
    "error result carries no code or a nonzero count")
  `STXD_ASSERT_NEXT(a_err_resync,
    in_accept && res_valid && res_item.kind == stxd_pkg::KIND_ERR,
    state_r.mode == stxd_pkg::MODE_HUNT && !state_r.esc_pend,
    "framing error did not return the receiver to hunting")
  `STXD_ASSERT_NOW(a_len_bound, state_r.mode == stxd_pkg::MODE_ASM && in_accept &&
    res_valid && res_item.kind == stxd_pkg::KIND_DATA,
    res_item.count != 16'd0 && res_item.count <= cfg_r.max_length,
    "payload count outside the configured limit")

endmodule
